// ----- hdl/lsd_pkg.sv -----
// Shared types, constants and arithmetic helpers for the lidar scan point decimator.
// Depends on nothing; every other file in hdl imports it.
package lsd_pkg;

    localparam int MAX_BEAMS = 2048;

    localparam int IDX_W   = 11;
    localparam int COORD_W = 18;
    localparam int SKIP_W  = 11;
    localparam int STEP_W  = 17;
    localparam int FAR_W   = 18;
    localparam int SQ_W    = 2 * (COORD_W + 1);
    localparam int SUM_W   = SQ_W + 2;
    localparam int STEP2_W = 2 * STEP_W;
    localparam int FAR2_W  = 2 * FAR_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef logic [IDX_W-1:0]          beam_idx_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0]                verdict_t;

    localparam verdict_t VERDICT_KEPT    = 2'd0;
    localparam verdict_t VERDICT_DROPPED = 2'd1;
    localparam verdict_t VERDICT_INVALID = 2'd2;

    // Highest beam index that passes unclamped.
    localparam int BEAM_TOP = (MAX_BEAMS - 1 > (1 << IDX_W) - 1) ?
                              (1 << IDX_W) - 1 : MAX_BEAMS - 1;
    localparam beam_idx_t BEAM_CLAMP = beam_idx_t'(BEAM_TOP);

    typedef enum logic [2:0] {
        REG_INDEX_GAP      = 3'd0,
        REG_SPATIAL_STEP   = 3'd1,
        REG_FAR_LIMIT      = 3'd2,
        REG_ORIGIN_X       = 3'd3,
        REG_ORIGIN_Y       = 3'd4,
        REG_ORIGIN_Z       = 3'd5,
        REG_SURROUND_FIRST = 3'd6,
        REG_SURROUND_LAST  = 3'd7
    } reg_idx_t;

    // Configuration as seen by the datapath; the two limits arrive squared.
    typedef struct packed {
        logic [SKIP_W-1:0]  index_gap;
        logic [STEP2_W-1:0] step2;
        logic [FAR2_W-1:0]  far2;
        coord_t             origin_x;
        coord_t             origin_y;
        coord_t             origin_z;
        beam_idx_t          surround_first;
        beam_idx_t          surround_last;
    } cfg_t;

    // One classified point as it travels from the front end to the back end.
    typedef struct packed {
        logic      first;
        beam_idx_t idx;
        logic      invalid;
        logic      forced;
        coord_t    x;
        coord_t    y;
        coord_t    z;
    } point_t;

    function automatic logic [SQ_W-1:0] sq_diff(input coord_t a, input coord_t b);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m * m;
    endfunction

    function automatic logic [SUM_W-1:0] sum3(input logic [SQ_W-1:0] a,
                                              input logic [SQ_W-1:0] b,
                                              input logic [SQ_W-1:0] c);
        return {2'b00, a} + {2'b00, b} + {2'b00, c};
    endfunction

endpackage

// ----- hdl/lsd_front.sv -----
// Front end: accepts point transactions, clamps the beam index and evaluates
// the state-free keep tests (far range, surround region). Uses lsd_pkg.
module lsd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              first_of_scan,
    input  lsd_pkg::beam_idx_t beam_index,
    input  logic [1:0]        prior_code,
    input  lsd_pkg::coord_t   point_x,
    input  lsd_pkg::coord_t   point_y,
    input  lsd_pkg::coord_t   point_z,
    input  lsd_pkg::cfg_t     cfg,
    output logic              push,
    output lsd_pkg::point_t   push_pt,
    input  logic              q_full
);
    import lsd_pkg::*;

    logic            s1_valid_reg;
    logic            s1_valid_next;
    point_t          s1_pt_reg;
    logic [SQ_W-1:0] sq_x_reg;
    logic [SQ_W-1:0] sq_y_reg;
    logic [SQ_W-1:0] sq_z_reg;
    logic            accept;
    beam_idx_t       idx_sat;
    logic            outside;
    logic [SUM_W-1:0] origin_sum;
    logic            far_hit;

    assign in_ready = !s1_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = s1_valid_reg && !q_full;

    assign idx_sat = (beam_index > BEAM_CLAMP) ? BEAM_CLAMP : beam_index;
    assign outside = (idx_sat < cfg.surround_first) || (idx_sat > cfg.surround_last);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pt_reg.first   <= first_of_scan;
            s1_pt_reg.idx     <= idx_sat;
            s1_pt_reg.invalid <= (prior_code != 2'd0);
            s1_pt_reg.forced  <= outside;
            s1_pt_reg.x       <= point_x;
            s1_pt_reg.y       <= point_y;
            s1_pt_reg.z       <= point_z;
            sq_x_reg          <= sq_diff(point_x, cfg.origin_x);
            sq_y_reg          <= sq_diff(point_y, cfg.origin_y);
            sq_z_reg          <= sq_diff(point_z, cfg.origin_z);
        end
    end

    assign origin_sum = sum3(sq_x_reg, sq_y_reg, sq_z_reg);
    assign far_hit    = origin_sum > {{(SUM_W - FAR2_W){1'b0}}, cfg.far2};

    always_comb
    begin
        push_pt        = s1_pt_reg;
        push_pt.forced = s1_pt_reg.forced || far_hit;
    end

endmodule

// ----- hdl/lsd_queue.sv -----
// Short register queue between the front end and the back end.
// Uses lsd_pkg for the point type.
module lsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lsd_pkg::point_t push_pt,
    output logic            full,
    input  logic            pop,
    output lsd_pkg::point_t head_pt,
    output logic            empty
);
    import lsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    point_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign head_pt = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_pt;
        end
    end

endmodule

// ----- hdl/lsd_back.sv -----
// Back end: tests points against the last kept point, updates the history
// and holds the verdict output register. Uses lsd_pkg.
module lsd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  lsd_pkg::point_t   head_pt,
    output logic              pop,
    input  lsd_pkg::cfg_t     cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output lsd_pkg::verdict_t verdict
);
    import lsd_pkg::*;

    logic            b1_valid_reg;
    logic            b1_valid_next;
    point_t          b1_pt_reg;
    logic [SQ_W-1:0] ksq_x_reg;
    logic [SQ_W-1:0] ksq_y_reg;
    logic [SQ_W-1:0] ksq_z_reg;

    logic            have_kept_reg;
    logic            have_kept_next;
    beam_idx_t       kept_index_reg;
    coord_t          kept_x_reg;
    coord_t          kept_y_reg;
    coord_t          kept_z_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    verdict_t        verdict_reg;
    verdict_t        verdict_next;

    logic            b1_move;
    logic            hazard;
    logic            history;
    logic            gap_hit;
    logic            dist_hit;
    logic            keep;
    logic            store;
    logic [SUM_W-1:0] kept_sum;
    logic [IDX_W:0]  gap_limit;

    // A point needs the kept registers as the point ahead of it leaves them,
    // so two valid points never sit back to back in the square stage.
    assign b1_move = b1_valid_reg && (!out_valid_reg || out_ready);
    assign hazard  = b1_valid_reg && !b1_pt_reg.invalid && !head_pt.invalid;
    assign pop     = !q_empty && (!b1_valid_reg || b1_move) && !hazard;

    assign history   = have_kept_reg && !b1_pt_reg.first;
    assign gap_limit = {1'b0, kept_index_reg} + {1'b0, cfg.index_gap};
    assign gap_hit   = {1'b0, b1_pt_reg.idx} > gap_limit;
    assign kept_sum  = sum3(ksq_x_reg, ksq_y_reg, ksq_z_reg);
    assign dist_hit  = kept_sum > {{(SUM_W - STEP2_W){1'b0}}, cfg.step2};
    assign keep      = !history || gap_hit || dist_hit || b1_pt_reg.forced;
    assign store     = b1_move && !b1_pt_reg.invalid && keep;

    always_comb
    begin
        b1_valid_next  = b1_valid_reg;
        out_valid_next = out_valid_reg;
        have_kept_next = have_kept_reg;
        verdict_next   = verdict_reg;
        if (pop)
        begin
            b1_valid_next = 1'b1;
        end
        else if (b1_move)
        begin
            b1_valid_next = 1'b0;
        end
        if (b1_move)
        begin
            out_valid_next = 1'b1;
            if (b1_pt_reg.invalid)
            begin
                verdict_next   = VERDICT_INVALID;
                have_kept_next = history;
            end
            else if (keep)
            begin
                verdict_next   = VERDICT_KEPT;
                have_kept_next = 1'b1;
            end
            else
            begin
                verdict_next   = VERDICT_DROPPED;
                have_kept_next = history;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            have_kept_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
            have_kept_reg <= have_kept_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        if (pop)
        begin
            b1_pt_reg <= head_pt;
            ksq_x_reg <= sq_diff(head_pt.x, kept_x_reg);
            ksq_y_reg <= sq_diff(head_pt.y, kept_y_reg);
            ksq_z_reg <= sq_diff(head_pt.z, kept_z_reg);
        end
        if (store)
        begin
            kept_index_reg <= b1_pt_reg.idx;
            kept_x_reg     <= b1_pt_reg.x;
            kept_y_reg     <= b1_pt_reg.y;
            kept_z_reg     <= b1_pt_reg.z;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

`ifndef ASSERT_OFF
    a_keep_updates_history: assert property (@(posedge clk) disable iff (!rst_n)
        store |=> (have_kept_reg && kept_index_reg == $past(b1_pt_reg.idx)))
        else $error("kept point did not update the history");

    a_drop_needs_history: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && verdict_reg == VERDICT_DROPPED) |-> have_kept_reg)
        else $error("point dropped with no kept point on record");

    a_invalid_holds_history: assert property (@(posedge clk) disable iff (!rst_n)
        (b1_move && b1_pt_reg.invalid) |=>
        ($stable(kept_index_reg) && $stable(kept_x_reg) && $stable(kept_y_reg)
         && $stable(kept_z_reg)))
        else $error("invalid point changed the kept point");

    a_no_stale_squares: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head_pt.invalid) |-> !(b1_valid_reg && !b1_pt_reg.invalid))
        else $error("point entered square stage behind an undecided point");
`endif

endmodule

// ----- hdl/lidar_scan_point_decimator.sv -----
// Top level of the lidar scan point decimator: APB register file, squared
// limits and the front end, queue and back end. Uses lsd_pkg and lsd_* modules.
//
//  Channel   Signals                                        Direction  Transaction
//  --------  ---------------------------------------------  ---------  ----------------------
//  points    in_valid/in_ready, first_of_scan, beam_index,  in         one projected point
//            prior_code, point_x, point_y, point_z
//  verdicts  out_valid/out_ready, verdict                   out        one verdict per point
//  config    psel, penable, pwrite, paddr, pwdata,          in/out     one register access
//            prdata, pready
//
// The front end takes one point transaction per cycle while in_ready is high. Invalid
// points pass the back end at one per cycle while the verdict output is not stalled; a
// valid point that follows another valid point waits in the queue until the point ahead
// has left the square stage, because its distance to the last kept point can only be
// squared once the point ahead has updated the kept-point registers. A stalled verdict
// output keeps the points flowing into the queue until it is full, and only then does
// in_ready fall. Reset clears all control state and loads the register defaults; no
// clearing pass is needed.
module lidar_scan_point_decimator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          first_of_scan,
    input  lsd_pkg::beam_idx_t            beam_index,
    input  logic [1:0]                    prior_code,
    input  lsd_pkg::coord_t               point_x,
    input  lsd_pkg::coord_t               point_y,
    input  lsd_pkg::coord_t               point_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lsd_pkg::verdict_t             verdict,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsd_pkg::ADDR_W-1:0]    paddr,
    input  logic [lsd_pkg::DATA_W-1:0]    pwdata,
    output logic [lsd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import lsd_pkg::*;

    // Register file. The two distance limits are also kept squared, in registers fed
    // from the limit registers, so the datapath only ever compares squares.
    logic [SKIP_W-1:0]  index_gap_reg;
    logic [STEP_W-1:0]  spatial_step_reg;
    logic [FAR_W-1:0]   far_limit_reg;
    coord_t             origin_x_reg;
    coord_t             origin_y_reg;
    coord_t             origin_z_reg;
    beam_idx_t          surround_first_reg;
    beam_idx_t          surround_last_reg;
    logic [STEP2_W-1:0] step2_reg;
    logic [FAR2_W-1:0]  far2_reg;

    logic     wr_en;
    reg_idx_t reg_sel;
    cfg_t     cfg;

    logic   push;
    point_t push_pt;
    logic   q_full;
    logic   pop;
    point_t head_pt;
    logic   q_empty;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_gap_reg      <= '0;
            spatial_step_reg   <= '0;
            far_limit_reg      <= FAR_W'(200000);
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            origin_z_reg       <= '0;
            surround_first_reg <= '0;
            surround_last_reg  <= '1;
            step2_reg          <= '0;
            far2_reg           <= FAR2_W'(64'd40000000000);
        end
        else
        begin
            step2_reg <= spatial_step_reg * spatial_step_reg;
            far2_reg  <= far_limit_reg * far_limit_reg;
            if (wr_en)
            begin
                unique case (reg_sel)
                    REG_INDEX_GAP:      index_gap_reg      <= pwdata[SKIP_W-1:0];
                    REG_SPATIAL_STEP:   spatial_step_reg   <= pwdata[STEP_W-1:0];
                    REG_FAR_LIMIT:      far_limit_reg      <= pwdata[FAR_W-1:0];
                    REG_ORIGIN_X:       origin_x_reg       <= pwdata[COORD_W-1:0];
                    REG_ORIGIN_Y:       origin_y_reg       <= pwdata[COORD_W-1:0];
                    REG_ORIGIN_Z:       origin_z_reg       <= pwdata[COORD_W-1:0];
                    REG_SURROUND_FIRST: surround_first_reg <= pwdata[IDX_W-1:0];
                    REG_SURROUND_LAST:  surround_last_reg  <= pwdata[IDX_W-1:0];
                endcase
            end
        end
    end

    // Read data; the signed origin registers come back sign-extended.
    always_comb
    begin
        unique case (reg_sel)
            REG_INDEX_GAP:      prdata = {{(DATA_W - SKIP_W){1'b0}}, index_gap_reg};
            REG_SPATIAL_STEP:   prdata = {{(DATA_W - STEP_W){1'b0}}, spatial_step_reg};
            REG_FAR_LIMIT:      prdata = {{(DATA_W - FAR_W){1'b0}}, far_limit_reg};
            REG_ORIGIN_X:       prdata = DATA_W'(origin_x_reg);
            REG_ORIGIN_Y:       prdata = DATA_W'(origin_y_reg);
            REG_ORIGIN_Z:       prdata = DATA_W'(origin_z_reg);
            REG_SURROUND_FIRST: prdata = {{(DATA_W - IDX_W){1'b0}}, surround_first_reg};
            REG_SURROUND_LAST:  prdata = {{(DATA_W - IDX_W){1'b0}}, surround_last_reg};
        endcase
    end

    always_comb
    begin
        cfg.index_gap      = index_gap_reg;
        cfg.step2          = step2_reg;
        cfg.far2           = far2_reg;
        cfg.origin_x       = origin_x_reg;
        cfg.origin_y       = origin_y_reg;
        cfg.origin_z       = origin_z_reg;
        cfg.surround_first = surround_first_reg;
        cfg.surround_last  = surround_last_reg;
    end

    // Front end: clamps the index, squares the distance to the scan origin and
    // folds the far-range and surround tests into one forced-keep flag.
    lsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_of_scan (first_of_scan),
        .beam_index    (beam_index),
        .prior_code    (prior_code),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .cfg           (cfg),
        .push          (push),
        .push_pt       (push_pt),
        .q_full        (q_full)
    );

    // Decouples the two halves so a stalled output does not stop intake at once.
    lsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_pt (push_pt),
        .full    (q_full),
        .pop     (pop),
        .head_pt (head_pt),
        .empty   (q_empty)
    );

    // Back end: beam gap and spatial step against the last kept point, then
    // the verdict and the history update.
    lsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_pt   (head_pt),
        .pop       (pop),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict)
    );

endmodule
